### design/stuffed_link_frame_receiver_unit_macros.svh
// Assertion macros used by the checker file of the frame receiver.
`ifndef STUFFED_LINK_FRAME_RECEIVER_UNIT_MACROS_SVH
`define STUFFED_LINK_FRAME_RECEIVER_UNIT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define SLFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never hold at a rising clock edge outside reset.
`define SLFR_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/slfr_pkg.sv
// Shared types, byte codes and result codes of the frame receiver.
package slfr_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

    localparam int TQ_DEPTH = 4;
    localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
    localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);

    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_MASK  = 8'h20;

    localparam logic [7:0] CTL_SET  = 8'h03;
    localparam logic [7:0] CTL_UA   = 8'h07;
    localparam logic [7:0] CTL_DISC = 8'h0B;
    localparam logic [7:0] CTL_I0   = 8'h00;
    localparam logic [7:0] CTL_I1   = 8'h40;

    localparam logic [7:0] LINK_ADDRESS_RESET = 8'h03;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] FT_SET       = 3'd0;
    localparam logic [2:0] FT_UA        = 3'd1;
    localparam logic [2:0] FT_DISC      = 3'd2;
    localparam logic [2:0] FT_INFO0     = 3'd3;
    localparam logic [2:0] FT_INFO1     = 3'd4;
    localparam logic [2:0] FT_MALFORMED = 3'd5;

    localparam logic [2:0] RP_NONE = 3'd0;
    localparam logic [2:0] RP_UA   = 3'd1;
    localparam logic [2:0] RP_RR0  = 3'd2;
    localparam logic [2:0] RP_RR1  = 3'd3;
    localparam logic [2:0] RP_REJ0 = 3'd4;
    localparam logic [2:0] RP_REJ1 = 3'd5;
    localparam logic [2:0] RP_DISC = 3'd6;

    typedef struct packed {
        logic       is_flag;
        logic       esc;
        logic [7:0] data;
    } tok_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [2:0] ftype;
        logic [2:0] reply;
    } res_t;

endpackage

### design/slfr_tok_fifo.sv
// Short token queue between the destuffing front and the frame back end.
module slfr_tok_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  slfr_pkg::tok_t      wr_tok,
    output logic                full,
    input  logic                rd_en,
    output slfr_pkg::tok_t      rd_tok,
    output logic                empty
);

    slfr_pkg::tok_t                    mem_reg [slfr_pkg::TQ_DEPTH];
    logic [slfr_pkg::TQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [slfr_pkg::TQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [slfr_pkg::TQ_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                              do_wr;
    logic                              do_rd;

    assign full   = (cnt_reg == slfr_pkg::TQ_CNT_W'(slfr_pkg::TQ_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_tok = mem_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### design/slfr_destuff.sv
// Front end: accepts line bytes, strips escapes and classifies flags and data.
module slfr_destuff (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           tok_full,
    output logic           tok_push,
    output slfr_pkg::tok_t tok
);

    logic esc_reg, esc_next;
    logic accept;

    assign accept = in_valid && !tok_full;

    always_comb
    begin
        esc_next     = esc_reg;
        tok_push     = 1'b0;
        tok.is_flag  = 1'b0;
        tok.esc      = esc_reg;
        tok.data     = esc_reg ? (in_byte ^ slfr_pkg::ESC_MASK) : in_byte;
        if (accept)
        begin
            if (in_byte == slfr_pkg::FLAG_BYTE)
            begin
                tok_push    = 1'b1;
                tok.is_flag = 1'b1;
                esc_next    = 1'b0;
            end
            else if (in_byte == slfr_pkg::ESC_BYTE && !esc_reg)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                tok_push = 1'b1;
                esc_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
        end
        else
        begin
            esc_reg <= esc_next;
        end
    end

endmodule

### design/slfr_frame.sv
// Back end: frame state machine over destuffed tokens, with a result queue.
module slfr_frame (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     link_address,
    input  logic           tok_empty,
    input  slfr_pkg::tok_t tok,
    output logic           tok_pop,
    input  logic           res_pop,
    output logic           res_empty,
    output slfr_pkg::res_t res
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_CTRL  = 3'd2;
    localparam logic [2:0] PH_HCHK  = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;
    localparam logic [2:0] PH_CLOSE = 3'd5;
    localparam logic [2:0] PH_BAD   = 3'd6;
    localparam logic [2:0] PH_OVER  = 3'd7;

    logic [2:0]                     phase_reg, phase_next;
    logic [7:0]                     ctrl_reg, ctrl_next;
    logic [7:0]                     chk_reg, chk_next;
    logic [7:0]                     held_reg, held_next;
    logic                           held_vld_reg, held_vld_next;
    logic [slfr_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    slfr_pkg::res_t                 oq_reg [slfr_pkg::OQ_DEPTH];
    logic [slfr_pkg::OQ_PTR_W-1:0]  oq_wr_reg, oq_rd_reg;
    logic [slfr_pkg::OQ_CNT_W-1:0]  oq_cnt_reg, oq_cnt_next;

    logic                           res_fire;
    logic                           emit;
    slfr_pkg::res_t                 res_new;
    logic [2:0]                     rej;
    logic                           ctl_ok;

    assign res_empty = (oq_cnt_reg == '0);
    assign res       = oq_reg[oq_rd_reg];
    assign res_fire  = res_pop && !res_empty;
    assign tok_pop   = !tok_empty &&
                       ((oq_cnt_reg != slfr_pkg::OQ_CNT_W'(slfr_pkg::OQ_DEPTH)) || res_fire);
    assign rej       = (ctrl_reg == slfr_pkg::CTL_I1) ? slfr_pkg::RP_REJ1 : slfr_pkg::RP_REJ0;
    assign ctl_ok    = (tok.data == slfr_pkg::CTL_SET) || (tok.data == slfr_pkg::CTL_UA) ||
                       (tok.data == slfr_pkg::CTL_DISC) || (tok.data == slfr_pkg::CTL_I0) ||
                       (tok.data == slfr_pkg::CTL_I1);

    always_comb
    begin
        phase_next     = phase_reg;
        ctrl_next      = ctrl_reg;
        chk_next       = chk_reg;
        held_next      = held_reg;
        held_vld_next  = held_vld_reg;
        cnt_next       = cnt_reg;
        emit           = 1'b0;
        res_new.kind    = slfr_pkg::KIND_VERDICT;
        res_new.payload = 8'h00;
        res_new.ftype   = slfr_pkg::FT_MALFORMED;
        res_new.reply   = slfr_pkg::RP_NONE;
        if (tok_pop)
        begin
            if (tok.is_flag)
            begin
                phase_next = PH_ADDR;
                case (phase_reg)
                    PH_HUNT:
                    begin
                        emit = 1'b0;
                    end
                    PH_ADDR:
                    begin
                        emit = tok.esc;
                    end
                    PH_CTRL, PH_HCHK, PH_BAD:
                    begin
                        emit = 1'b1;
                    end
                    PH_CLOSE:
                    begin
                        emit = 1'b1;
                        if (tok.esc)
                        begin
                            res_new.ftype = slfr_pkg::FT_MALFORMED;
                        end
                        else if (ctrl_reg == slfr_pkg::CTL_SET)
                        begin
                            res_new.ftype = slfr_pkg::FT_SET;
                            res_new.reply = slfr_pkg::RP_UA;
                        end
                        else if (ctrl_reg == slfr_pkg::CTL_UA)
                        begin
                            res_new.ftype = slfr_pkg::FT_UA;
                        end
                        else
                        begin
                            res_new.ftype = slfr_pkg::FT_DISC;
                            res_new.reply = slfr_pkg::RP_DISC;
                        end
                    end
                    PH_OVER:
                    begin
                        emit          = 1'b1;
                        res_new.reply = rej;
                    end
                    PH_BODY:
                    begin
                        emit = 1'b1;
                        if (tok.esc || !held_vld_reg || held_reg != chk_reg)
                        begin
                            res_new.reply = rej;
                        end
                        else if (ctrl_reg == slfr_pkg::CTL_I1)
                        begin
                            res_new.ftype = slfr_pkg::FT_INFO1;
                            res_new.reply = slfr_pkg::RP_RR0;
                        end
                        else
                        begin
                            res_new.ftype = slfr_pkg::FT_INFO0;
                            res_new.reply = slfr_pkg::RP_RR1;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_ADDR:
                    begin
                        if (tok.data == link_address)
                        begin
                            chk_next   = tok.data;
                            phase_next = PH_CTRL;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_CTRL:
                    begin
                        if (ctl_ok)
                        begin
                            ctrl_next  = tok.data;
                            chk_next   = chk_reg ^ tok.data;
                            phase_next = PH_HCHK;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_HCHK:
                    begin
                        if (tok.data != chk_reg)
                        begin
                            phase_next = PH_BAD;
                        end
                        else if (ctrl_reg == slfr_pkg::CTL_I0 || ctrl_reg == slfr_pkg::CTL_I1)
                        begin
                            chk_next      = 8'h00;
                            held_vld_next = 1'b0;
                            held_next     = 8'h00;
                            cnt_next      = '0;
                            phase_next    = PH_BODY;
                        end
                        else
                        begin
                            phase_next = PH_CLOSE;
                        end
                    end
                    PH_CLOSE:
                    begin
                        phase_next = PH_BAD;
                    end
                    PH_BODY:
                    begin
                        if (!held_vld_reg)
                        begin
                            held_next     = tok.data;
                            held_vld_next = 1'b1;
                        end
                        else if (cnt_reg >= slfr_pkg::CNT_W'(slfr_pkg::MAX_PAYLOAD))
                        begin
                            phase_next    = PH_OVER;
                            held_vld_next = 1'b0;
                        end
                        else
                        begin
                            chk_next        = chk_reg ^ held_reg;
                            cnt_next        = cnt_reg + 1'b1;
                            held_next       = tok.data;
                            emit            = 1'b1;
                            res_new.kind    = slfr_pkg::KIND_PAYLOAD;
                            res_new.payload = held_reg;
                            res_new.ftype   = slfr_pkg::FT_SET;
                            res_new.reply   = slfr_pkg::RP_NONE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (emit && !res_fire)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (res_fire && !emit)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oq_reg[oq_wr_reg] <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            ctrl_reg     <= 8'h00;
            chk_reg      <= 8'h00;
            held_reg     <= 8'h00;
            held_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_cnt_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ctrl_reg     <= ctrl_next;
            chk_reg      <= chk_next;
            held_reg     <= held_next;
            held_vld_reg <= held_vld_next;
            cnt_reg      <= cnt_next;
            oq_cnt_reg   <= oq_cnt_next;
            if (emit)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (res_fire)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
        end
    end

endmodule

### design/stuffed_link_frame_receiver_unit.sv
// Top level of the byte-stuffed link frame receiver.
// The input side is a queue: drive a raw line byte on rx_byte with push high;
// the beat is taken at a rising edge where full is low. The result side is a
// queue too: while empty is low the oldest result sits on result_kind,
// payload_byte, frame_type and reply, and pop high at a rising edge takes it.
// A result of kind 0 is one destuffed payload byte; kind 1 is the verdict
// given at the closing flag of a frame, with frame type and the reply owed.
// The expected address is written through link_address_we and link_address; the user must write it
// only while the block is idle, which the block itself does not enforce; it resets to 3.
// One byte is accepted every cycle while full is low. A result shows on the
// outputs once the beat that caused it has passed the destuffing front into its
// token queue and then the frame state machine into its result queue.
// When the receiver holds pop low, the result queue fills, the frame machine
// stops, the four-entry token queue fills, and full rises; nothing is lost.
// Reset empties both queues, clears any pending escape and puts the frame
// machine back to hunting for an opening flag.
module stuffed_link_frame_receiver_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic       result_kind,
    output logic [7:0] payload_byte,
    output logic [2:0] frame_type,
    output logic [2:0] reply,
    input  logic       link_address_we,
    input  logic [7:0] link_address
);

    logic [7:0]     link_address_reg;
    logic           tq_push;
    logic           tq_full;
    logic           tq_pop;
    logic           tq_empty;
    slfr_pkg::tok_t tq_wr_tok;
    slfr_pkg::tok_t tq_rd_tok;
    slfr_pkg::res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_address_reg <= slfr_pkg::LINK_ADDRESS_RESET;
        end
        else if (link_address_we)
        begin
            link_address_reg <= link_address;
        end
    end

    assign full = tq_full;

    slfr_destuff u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push),
        .in_byte  (rx_byte),
        .tok_full (tq_full),
        .tok_push (tq_push),
        .tok      (tq_wr_tok)
    );

    slfr_tok_fifo u_tq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (tq_push),
        .wr_tok (tq_wr_tok),
        .full   (tq_full),
        .rd_en  (tq_pop),
        .rd_tok (tq_rd_tok),
        .empty  (tq_empty)
    );

    slfr_frame u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .link_address (link_address_reg),
        .tok_empty    (tq_empty),
        .tok          (tq_rd_tok),
        .tok_pop      (tq_pop),
        .res_pop      (pop),
        .res_empty    (empty),
        .res          (res)
    );

    assign result_kind  = res.kind;
    assign payload_byte = res.payload;
    assign frame_type   = res.ftype;
    assign reply        = res.reply;

endmodule

### design/slfr_checker.sv
// Port-level checks on the result channel of the frame receiver, bound to the top level.
`include "stuffed_link_frame_receiver_unit_macros.svh"

module slfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       result_kind,
    input logic [2:0] frame_type,
    input logic [2:0] reply
);

    `SLFR_ASSERT(a_payload_codes_zero, (!empty && result_kind == slfr_pkg::KIND_PAYLOAD) |-> (frame_type == slfr_pkg::FT_SET && reply == slfr_pkg::RP_NONE), "Payload beat carries a frame type or reply.")

    `SLFR_NEVER(a_malformed_reply, !empty && result_kind == slfr_pkg::KIND_VERDICT && frame_type == slfr_pkg::FT_MALFORMED && reply != slfr_pkg::RP_NONE && reply != slfr_pkg::RP_REJ0 && reply != slfr_pkg::RP_REJ1, "Malformed verdict owes a reply other than none or reject.")

    `SLFR_NEVER(a_info_ack, !empty && result_kind == slfr_pkg::KIND_VERDICT && ((frame_type == slfr_pkg::FT_INFO0 && reply != slfr_pkg::RP_RR1) || (frame_type == slfr_pkg::FT_INFO1 && reply != slfr_pkg::RP_RR0)), "Good information frame does not acknowledge the next sequence number.")

    `SLFR_ASSERT(a_stall_holds, (!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(frame_type) && $stable(reply)), "Stalled result beat changed or vanished.")

endmodule

bind stuffed_link_frame_receiver_unit slfr_checker u_slfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .result_kind (result_kind),
    .frame_type  (frame_type),
    .reply       (reply)
);

### bench/slfr_frame_check_pkg.sv
// Scoreboard for the frame receiver: a byte-level frame predictor and its expected results.
`timescale 1ns / 1ps

package slfr_frame_check_pkg;

    import slfr_pkg::*;

    typedef enum logic [2:0] {
        HUNTING,
        AT_ADDRESS,
        AT_CONTROL,
        AT_HEADER_CHECK,
        IN_BODY,
        AWAIT_CLOSE,
        DISCARDING,
        OVERFLOWED
    } rx_phase_e;

    class frame_result_scoreboard;

        logic [7:0]  link_addr;
        rx_phase_e   phase;
        logic        escape_pending;
        logic [7:0]  control_seen;
        logic [7:0]  running_check;
        logic [7:0]  held_byte;
        logic        held_valid;
        int unsigned payload_count;
        res_t        expected_q[$];
        int unsigned failures;

        function new();
            link_addr      = LINK_ADDRESS_RESET;
            phase          = HUNTING;
            escape_pending = 1'b0;
            control_seen   = 8'h00;
            running_check  = 8'h00;
            held_byte      = 8'h00;
            held_valid     = 1'b0;
            payload_count  = 0;
            failures       = 0;
        endfunction

        function void set_link_address(logic [7:0] value);
            link_addr = value;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        function logic [2:0] reject_reply();
            return (control_seen == CTL_I1) ? RP_REJ1 : RP_REJ0;
        endfunction

        function void add_verdict(logic [2:0] ftype, logic [2:0] reply);
            res_t r;
            r.kind    = KIND_VERDICT;
            r.payload = 8'h00;
            r.ftype   = ftype;
            r.reply   = reply;
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] raw);
            logic       esc;
            logic [7:0] b;
            rx_phase_e  was;
            res_t       r;
            was = phase;
            if (raw == FLAG_BYTE)
            begin
                esc = escape_pending;
                escape_pending = 1'b0;
                phase = AT_ADDRESS;
                case (was)
                    HUNTING: ;
                    AT_ADDRESS:
                    begin
                        if (esc)
                            add_verdict(FT_MALFORMED, RP_NONE);
                    end
                    AT_CONTROL, AT_HEADER_CHECK, DISCARDING:
                        add_verdict(FT_MALFORMED, RP_NONE);
                    AWAIT_CLOSE:
                    begin
                        if (control_seen == CTL_SET)
                            add_verdict(FT_SET, RP_UA);
                        else if (control_seen == CTL_UA)
                            add_verdict(FT_UA, RP_NONE);
                        else
                            add_verdict(FT_DISC, RP_DISC);
                    end
                    OVERFLOWED:
                        add_verdict(FT_MALFORMED, reject_reply());
                    default:
                    begin
                        if (esc || !held_valid || held_byte != running_check)
                            add_verdict(FT_MALFORMED, reject_reply());
                        else if (control_seen == CTL_I1)
                            add_verdict(FT_INFO1, RP_RR0);
                        else
                            add_verdict(FT_INFO0, RP_RR1);
                    end
                endcase
                return;
            end
            if (was == HUNTING || was == DISCARDING || was == OVERFLOWED)
                return;
            if (was == AWAIT_CLOSE)
            begin
                phase = DISCARDING;
                return;
            end
            if (raw == ESC_BYTE && !escape_pending)
            begin
                escape_pending = 1'b1;
                return;
            end
            b = escape_pending ? (raw ^ ESC_MASK) : raw;
            escape_pending = 1'b0;
            case (was)
                AT_ADDRESS:
                begin
                    if (b == link_addr)
                    begin
                        running_check = b;
                        phase = AT_CONTROL;
                    end
                    else
                        phase = DISCARDING;
                end
                AT_CONTROL:
                begin
                    if (b == CTL_SET || b == CTL_UA || b == CTL_DISC ||
                        b == CTL_I0 || b == CTL_I1)
                    begin
                        control_seen = b;
                        running_check ^= b;
                        phase = AT_HEADER_CHECK;
                    end
                    else
                        phase = DISCARDING;
                end
                AT_HEADER_CHECK:
                begin
                    if (b != running_check)
                        phase = DISCARDING;
                    else if (control_seen == CTL_I0 || control_seen == CTL_I1)
                    begin
                        running_check = 8'h00;
                        held_valid = 1'b0;
                        held_byte = 8'h00;
                        payload_count = 0;
                        phase = IN_BODY;
                    end
                    else
                        phase = AWAIT_CLOSE;
                end
                default:
                begin
                    if (held_valid)
                    begin
                        if (payload_count >= MAX_PAYLOAD)
                        begin
                            phase = OVERFLOWED;
                            held_valid = 1'b0;
                        end
                        else
                        begin
                            running_check ^= held_byte;
                            payload_count++;
                            r.kind    = KIND_PAYLOAD;
                            r.payload = held_byte;
                            r.ftype   = 3'd0;
                            r.reply   = RP_NONE;
                            expected_q.push_back(r);
                            held_byte = b;
                        end
                    end
                    else
                    begin
                        held_byte = b;
                        held_valid = 1'b1;
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: kind %0d byte %02h type %0d reply %0d",
                       got.kind, got.payload, got.ftype, got.reply);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("payload_byte", want.payload, got.payload);
            compare_field("frame_type", want.ftype, got.ftype);
            compare_field("reply", want.reply, got.reply);
        endfunction

    endclass

endpackage

### bench/testbench.sv
// Top-level testbench of the frame receiver: clock, reset, beat drivers and test phases.
`timescale 1ns / 1ps

module testbench;

    import slfr_pkg::*;
    import slfr_frame_check_pkg::*;

    typedef enum int {
        FR_INFO,
        FR_UNNUMBERED,
        FR_BAD_CHECK,
        FR_NO_CHECK,
        FR_BAD_ADDR,
        FR_BAD_CTRL,
        FR_BAD_HCHK,
        FR_SHORT,
        FR_EXTRA,
        FR_DANGLING,
        FR_NOISE
    } frame_shape_e;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] rx_byte;
    logic       empty;
    logic       pop;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [2:0] frame_type;
    logic [2:0] reply;
    logic       link_address_we;
    logic [7:0] link_address;

    frame_result_scoreboard board;
    logic [7:0]  line_q[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_cycles    = 0;

    stuffed_link_frame_receiver_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .empty           (empty),
        .pop             (pop),
        .result_kind     (result_kind),
        .payload_byte    (payload_byte),
        .frame_type      (frame_type),
        .reply           (reply),
        .link_address_we (link_address_we),
        .link_address    (link_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL stuffed_link_frame_receiver_unit");
        $finish;
    end

    initial
    begin
        res_t seen;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                seen.kind    = result_kind;
                seen.payload = payload_byte;
                seen.ftype   = frame_type;
                seen.reply   = reply;
                board.check_result(seen);
            end
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles--;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_line();
        logic [7:0] b;
        while (line_q.size() > 0)
        begin
            b = line_q.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
            push <= 1'b1;
            rx_byte <= b;
            @(posedge clk);
            while (full)
                @(posedge clk);
            board.note_byte(b);
        end
        push <= 1'b0;
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        while (board.outstanding() > 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_link_address(logic [7:0] value);
        link_address_we <= 1'b1;
        link_address <= value;
        @(posedge clk);
        link_address_we <= 1'b0;
        board.set_link_address(value);
    endtask

    function automatic void put_stuffed(logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE || (b != 8'h5E && $urandom_range(15) == 0))
        begin
            line_q.push_back(ESC_BYTE);
            line_q.push_back(b ^ ESC_MASK);
        end
        else
            line_q.push_back(b);
    endfunction

    function automatic void add_frame(frame_shape_e shape, logic [7:0] addr, int unsigned len);
        logic [7:0] a;
        logic [7:0] ctl;
        logic [7:0] chk;
        logic [7:0] d;
        logic       numbered;
        if ($urandom_range(3) == 0)
            line_q.push_back(FLAG_BYTE);
        if (shape == FR_NOISE)
        begin
            repeat ($urandom_range(1, 6))
                line_q.push_back(8'($urandom_range(255)));
            line_q.push_back(FLAG_BYTE);
            return;
        end
        numbered = (shape == FR_INFO || shape == FR_BAD_CHECK || shape == FR_NO_CHECK ||
                    shape == FR_DANGLING || ($urandom_range(1) == 0 && shape != FR_UNNUMBERED &&
                    shape != FR_EXTRA));
        if (numbered)
            ctl = $urandom_range(1) ? CTL_I1 : CTL_I0;
        else
            case ($urandom_range(2))
                0: ctl = CTL_SET;
                1: ctl = CTL_UA;
                default: ctl = CTL_DISC;
            endcase
        if (shape == FR_BAD_CTRL)
        begin
            numbered = 1'b0;
            do
                ctl = 8'($urandom_range(255));
            while (ctl == CTL_SET || ctl == CTL_UA || ctl == CTL_DISC ||
                   ctl == CTL_I0 || ctl == CTL_I1);
        end
        a = (shape == FR_BAD_ADDR) ? (addr ^ 8'($urandom_range(1, 255))) : addr;
        put_stuffed(a);
        if (shape == FR_SHORT)
        begin
            if ($urandom_range(1))
                put_stuffed(ctl);
            line_q.push_back(FLAG_BYTE);
            return;
        end
        put_stuffed(ctl);
        chk = a ^ ctl;
        if (shape == FR_BAD_HCHK)
            chk ^= 8'($urandom_range(1, 255));
        put_stuffed(chk);
        if (numbered)
        begin
            chk = 8'h00;
            if (shape == FR_NO_CHECK)
                len = 0;
            repeat (len)
            begin
                d = 8'($urandom_range(255));
                chk ^= d;
                put_stuffed(d);
            end
            if (shape == FR_DANGLING)
                line_q.push_back(ESC_BYTE);
            else if (shape == FR_BAD_CHECK)
                put_stuffed(chk ^ 8'($urandom_range(1, 255)));
            else if (shape != FR_NO_CHECK)
                put_stuffed(chk);
        end
        if (shape == FR_EXTRA)
            repeat ($urandom_range(1, 3))
            begin
                d = 8'($urandom_range(255));
                line_q.push_back(d == FLAG_BYTE ? ESC_BYTE : d);
            end
        line_q.push_back(FLAG_BYTE);
    endfunction

    function automatic void add_random_frame(logic [7:0] addr);
        int unsigned r;
        frame_shape_e shape;
        r = $urandom_range(99);
        if (r < 45)
            shape = FR_INFO;
        else if (r < 60)
            shape = FR_UNNUMBERED;
        else if (r < 65)
            shape = FR_BAD_CHECK;
        else if (r < 68)
            shape = FR_NO_CHECK;
        else if (r < 73)
            shape = FR_BAD_ADDR;
        else if (r < 78)
            shape = FR_BAD_CTRL;
        else if (r < 83)
            shape = FR_BAD_HCHK;
        else if (r < 88)
            shape = FR_SHORT;
        else if (r < 92)
            shape = FR_EXTRA;
        else if (r < 96)
            shape = FR_DANGLING;
        else
            shape = FR_NOISE;
        add_frame(shape, addr, $urandom_range(0, 16));
    endfunction

    initial
    begin
        logic [7:0] addr;
        push <= 1'b0;
        rx_byte <= 8'h00;
        link_address_we <= 1'b0;
        link_address <= LINK_ADDRESS_RESET;
        rst_n <= 1'b0;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        line_q = {8'h41,
                  FLAG_BYTE, 8'h03, CTL_SET, 8'h00, FLAG_BYTE,
                  8'h03, CTL_UA, 8'h04, FLAG_BYTE,
                  8'h03, CTL_DISC, 8'h08, FLAG_BYTE,
                  FLAG_BYTE,
                  8'h03, CTL_I1, 8'h43, 8'h00, 8'hFF, ESC_BYTE, 8'h5E,
                  ESC_BYTE, ESC_BYTE, 8'hDC, FLAG_BYTE,
                  8'h03, CTL_I0, 8'h03, 8'h12, 8'h34, FLAG_BYTE,
                  8'h03, CTL_I0, 8'h03, FLAG_BYTE,
                  8'h03, CTL_SET, 8'h00, 8'h55, FLAG_BYTE,
                  8'h03, FLAG_BYTE,
                  8'h03, CTL_I1, 8'h43, 8'h9A, ESC_BYTE, FLAG_BYTE,
                  ESC_BYTE, FLAG_BYTE};
        send_line();
        settle();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: addr = 8'h00;
                1: addr = 8'hFF;
                2: addr = FLAG_BYTE;
                3: addr = ESC_BYTE;
                default: addr = 8'($urandom_range(255));
            endcase
            write_link_address(addr);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 17;
                    recv_stall_pct = 17;
                end
            endcase
            if (p == 0)
                hold_cycles = 300;
            while (line_q.size() < 120)
                add_random_frame(addr);
            if (p == 2)
                add_frame(FR_INFO, addr, MAX_PAYLOAD);
            if (p >= 3)
                add_frame(FR_INFO, addr, MAX_PAYLOAD + $urandom_range(1, 3));
            add_random_frame(addr);
            send_line();
            settle();
        end

        if (board.outstanding() > 0)
        begin
            $error("%0d expected results never arrived", board.outstanding());
            board.failures++;
        end
        if (board.failures == 0)
            $display("PASS stuffed_link_frame_receiver_unit");
        else
            $display("FAIL stuffed_link_frame_receiver_unit");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/slfr_pkg.sv
design/slfr_tok_fifo.sv
design/slfr_destuff.sv
design/slfr_frame.sv
design/stuffed_link_frame_receiver_unit.sv
design/slfr_checker.sv
bench/slfr_frame_check_pkg.sv
bench/testbench.sv
